FILE: sv/mclpd_pkg.sv
// ----------------------------------------------------------------------------
// mclpd_pkg
// Shared types and constants of the multi-channel length-prefix deframer.
// ----------------------------------------------------------------------------
package mclpd_pkg;

  localparam int unsigned CONN_W       = 6;
  localparam int unsigned CONN_SPACE   = 1 << CONN_W;
  localparam int unsigned NUM_CONN_DEF = 64;
  localparam int unsigned SEEN_W       = 3;
  localparam int unsigned LEN_W        = 32;
  localparam logic [SEEN_W-1:0] LEN_BYTES = SEEN_W'(4);

  typedef enum logic {
    ACT_DATA  = 1'b0,
    ACT_CLEAR = 1'b1
  } act_e;

  // per-connection context, one memory word
  typedef struct packed {
    logic [SEEN_W-1:0] seen;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  cnt;
  } ctx_t;

  typedef struct packed {
    logic             vld;
    logic             has_byte;
    logic             last;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } res_t;

endpackage

FILE: sv/mclpd_ram.sv
// ----------------------------------------------------------------------------
// mclpd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mclpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/mclpd_upd.sv
// ----------------------------------------------------------------------------
// mclpd_upd
// Context update: clear, length assembly, payload counting and result forming.
// ----------------------------------------------------------------------------
module mclpd_upd
  import mclpd_pkg::*;
(
  input  ctx_t       ctx_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  output ctx_t       ctx_o,
  output res_t       res_o
);

  logic [LEN_W-1:0]  new_len;
  logic [LEN_W-1:0]  cnt_inc;
  logic [SEEN_W-1:0] seen_inc;

  assign cnt_inc  = ctx_i.cnt + LEN_W'(1);
  assign seen_inc = ctx_i.seen + SEEN_W'(1);

  always_comb begin
    new_len = ctx_i.len;
    for (int i = 0; i < 4; i++) begin
      if (ctx_i.seen[1:0] == 2'(i)) begin
        new_len[i*8 +: 8] = byte_i;
      end
    end
  end

  always_comb begin
    ctx_o = '0;
    res_o = '0;
    if (clear_i) begin
      ctx_o = '0;
    end else if (ctx_i.seen >= LEN_BYTES) begin
      // payload phase
      res_o.vld      = 1'b1;
      res_o.has_byte = 1'b1;
      res_o.data     = byte_i;
      res_o.len      = ctx_i.len;
      if (cnt_inc >= ctx_i.len) begin
        res_o.last = 1'b1;
        ctx_o      = '0;
      end else begin
        ctx_o     = ctx_i;
        ctx_o.cnt = cnt_inc;
      end
    end else begin
      ctx_o.seen = seen_inc;
      ctx_o.len  = new_len;
      ctx_o.cnt  = ctx_i.cnt;
      // zero length: empty frame end on the fourth length byte
      if (seen_inc == LEN_BYTES && new_len == '0) begin
        res_o.vld  = 1'b1;
        res_o.last = 1'b1;
        ctx_o      = '0;
      end
    end
  end

endmodule

FILE: sv/multi_channel_length_prefix_deframer.sv
// ----------------------------------------------------------------------------
// multi_channel_length_prefix_deframer
// Per-connection deframer for 32-bit little-endian length-prefixed frames.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one request per byte: a data
// byte or a context clear for conn_id_i. The first four data bytes of a frame
// on a connection form the payload length, LSB first, and give no output. Each
// payload byte is sent on the output channel (out_valid_o / out_stall_i) with
// its connection and frame length; frame_last_o marks the final one. A zero
// length gives a single empty frame end (has_byte_o low). Connection numbers
// of NUM_CONN and above are accepted and dropped.
// Path: a taken request is registered into the update stage, where its
// context is read and updated, and its result goes to the output register.
// Throughput: one request per cycle while the output register is not blocked,
// set by the context memory's single read and single write port; a one-entry
// forward covers back-to-back requests on the same connection.
// Reset: per-entry valid flops make every context read as zero, so requests
// are taken from the first cycle after reset with no clearing pass.
// Stall: a result waits in the output register; the input is stalled only
// when a request sits in the update stage and that register is blocked.
// ----------------------------------------------------------------------------
module multi_channel_length_prefix_deframer
  import mclpd_pkg::*;
#(
  parameter int unsigned NUM_CONN = NUM_CONN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [CONN_W-1:0] conn_id_i,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CONN_W-1:0] out_conn_o,
  output logic [7:0]        payload_byte_o,
  output logic              has_byte_o,
  output logic              frame_last_o,
  output logic [LEN_W-1:0]  frame_length_o
);

  localparam int unsigned AW = (NUM_CONN > 1) ? $clog2(NUM_CONN) : 1;
  localparam int unsigned CW = $bits(ctx_t);

  logic                  in_acc;
  logic                  s1_go;
  logic                  ram_we;
  logic [CW-1:0]         ram_rdata;
  ctx_t                  rd_ctx;
  ctx_t                  cur_ctx;
  ctx_t                  wr_ctx;
  res_t                  res;

  logic                  s1_vld_q;
  logic                  s1_clear_q;
  logic                  s1_inr_q;
  logic [CONN_W-1:0]     s1_conn_q;
  logic [7:0]            s1_byte_q;
  logic                  fwd_hit_q;
  ctx_t                  fwd_ctx_q;
  logic [CONN_SPACE-1:0] ent_vld_q;

  logic                  out_vld_q;
  logic [CONN_W-1:0]     out_conn_q;
  res_t                  out_res_q;

  assign in_stall_o = s1_vld_q && out_vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_go      = s1_vld_q && !(out_vld_q && out_stall_i);
  assign ram_we     = s1_go && s1_inr_q;

  mclpd_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_CONN)
  ) u_ctx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(s1_conn_q)),
    .wdata_i (wr_ctx),
    .re_i    (in_acc),
    .raddr_i (AW'(conn_id_i)),
    .rdata_o (ram_rdata)
  );

  assign rd_ctx = ctx_t'(ram_rdata);

  // forward the word written on the edge this request was read; unwritten entries read as zero
  always_comb begin
    if (fwd_hit_q) begin
      cur_ctx = fwd_ctx_q;
    end else if (ent_vld_q[s1_conn_q]) begin
      cur_ctx = rd_ctx;
    end else begin
      cur_ctx = '0;
    end
  end

  mclpd_upd u_upd (
    .ctx_i   (cur_ctx),
    .clear_i (s1_clear_q),
    .byte_i  (s1_byte_q),
    .ctx_o   (wr_ctx),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q  <= 1'b1;
      fwd_hit_q <= ram_we && (s1_conn_q == conn_id_i);
    end else if (s1_go) begin
      s1_vld_q  <= 1'b0;
      fwd_hit_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_clear_q <= (act_e'(action_i) == ACT_CLEAR);
      s1_inr_q   <= (32'(conn_id_i) < 32'(NUM_CONN));
      s1_conn_q  <= conn_id_i;
      s1_byte_q  <= rx_byte_i;
      fwd_ctx_q  <= wr_ctx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (ram_we) begin
      ent_vld_q[s1_conn_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ram_we && res.vld) begin
      out_vld_q <= 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we && res.vld) begin
      out_conn_q <= s1_conn_q;
      out_res_q  <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_conn_o     = out_conn_q;
  assign payload_byte_o = out_res_q.data;
  assign has_byte_o     = out_res_q.has_byte;
  assign frame_last_o   = out_res_q.last;
  assign frame_length_o = out_res_q.len;

  // an empty frame end carries no byte and a zero length
  a_empty_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_res_q.has_byte) |->
      (out_res_q.last && out_res_q.len == '0 && out_res_q.data == '0))
    else $error("malformed empty frame end");

  // a byte that does not close its frame belongs to a nonempty frame
  a_mid_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_res_q.last) |-> (out_res_q.len != '0))
    else $error("mid-frame byte with zero length");

  // the length-byte count written back never exceeds four
  a_seen_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (wr_ctx.seen <= LEN_BYTES))
    else $error("length byte count out of range");

  // a forward is only armed for a request that sits in the update stage
  a_fwd_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_vld_q)
    else $error("forward without request in update stage");

endmodule
